>>> sv/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg: shared definitions for the sorted alarm timer queue.
// Holds sizes, operation and result codes, the queue entry type and the
// circular pointer helper.
// ----------------------------------------------------------------------------
package satq_pkg;

  localparam int NUM_ALARMS = 16;
  localparam int AW         = $clog2(NUM_ALARMS);
  localparam int CW         = $clog2(NUM_ALARMS + 1);
  localparam int ID_W       = 4;
  localparam int TIME_W     = 64;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_SLEEP = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  localparam logic [2:0] K_INIT   = 3'd0;
  localparam logic [2:0] K_QUEUED = 3'd1;
  localparam logic [2:0] K_DUE    = 3'd2;
  localparam logic [2:0] K_WOKEN  = 3'd3;
  localparam logic [2:0] K_REJECT = 3'd4;
  localparam logic [2:0] K_NONE   = 3'd5;

  // One wake queue entry: the slot and a copy of its wake time.
  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   slot;
  } q_entry_t;

  // Circular pointer plus offset, wrapping at NUM_ALARMS.
  function automatic logic [AW-1:0] qptr_add(input logic [AW-1:0] ptr,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW+1-AW){1'b0}}, ptr} + {1'b0, off};
    if (sum >= (CW+1)'(NUM_ALARMS)) begin
      sum = sum - (CW+1)'(NUM_ALARMS);
    end
    return sum[AW-1:0];
  endfunction

endpackage

>>> sv/sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue: alarm engine with a time-sorted wake queue.
// Base times and the circular wake queue live in two synchronous memories.
// ----------------------------------------------------------------------------
// Sequence: init and reject go straight to S_OUT after acceptance; a sleep passes
// S_SLEEP, which answers an already-due sleep, or goes on to the sorted insert walk
// in S_INS, moving later entries up, and to S_INS_HEAD if it becomes the head; a
// tick walks S_TICK, waking due alarms in order. One word at a time: a new word is
// taken only after the last result word of the previous one has been accepted.
// Reset: base times read as zero, queue empty, compare all ones, irq off.
module sorted_alarm_timer_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  // tdata, low to high: alarm_id[3:0], delay_ticks[67:4], now_time[131:68]
  input  logic [135:0]   s_axis_tdata_i,
  // tuser: operation[1:0]
  input  logic [1:0]     s_axis_tuser_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // tdata, low to high: woken_id[3:0], compare_time[67:4], interrupt_on[68]
  output logic [71:0]    m_axis_tdata_o,
  // tuser: kind[2:0]
  output logic [2:0]     m_axis_tuser_o,
  output logic           m_axis_tlast_o
);

  localparam int N  = satq_pkg::NUM_ALARMS;
  localparam int AW = satq_pkg::AW;
  localparam int CW = satq_pkg::CW;
  localparam int IW = satq_pkg::ID_W;
  localparam int TW = satq_pkg::TIME_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SLEEP    = 3'd1;
  localparam logic [2:0] S_INS      = 3'd2;
  localparam logic [2:0] S_INS_HEAD = 3'd3;
  localparam logic [2:0] S_TICK     = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  // Input word unpacked.
  logic [1:0]    in_op;
  logic [IW-1:0] in_id;
  logic [TW-1:0] in_delay;
  logic [TW-1:0] in_now;
  assign in_op    = s_axis_tuser_i;
  assign in_id    = s_axis_tdata_i[3:0];
  assign in_delay = s_axis_tdata_i[67:4];
  assign in_now   = s_axis_tdata_i[131:68];

  // Control and payload registers.
  logic [2:0]    state_q, state_d;
  logic [IW-1:0] id_q, id_d;
  logic [TW-1:0] delay_q, delay_d;
  logic [TW-1:0] now_q, now_d;
  logic [TW-1:0] newb_q, newb_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N-1:0]  flags_q, flags_d;
  logic [N-1:0]  bvalid_q, bvalid_d;
  logic [TW-1:0] cmp_q, cmp_d;
  logic          irq_q, irq_d;
  logic [2:0]    rkind_q, rkind_d;
  logic [IW-1:0] rid_q, rid_d;
  logic [CW-1:0] nres_q, nres_d;
  logic [CW-1:0] ocnt_q, ocnt_d;
  logic [CW-1:0] wcnt_q, wcnt_d;

  // Woken slots of the current tick, replayed on the output.
  logic [IW-1:0] wbuf_q [N];
  logic          wbuf_we;

  // Base time memory and its read port.
  logic [TW-1:0] bmem [N];
  logic          b_we;
  logic [AW-1:0] b_addr;
  logic [TW-1:0] b_wdata;
  logic [TW-1:0] b_rdata_q;
  logic          b_rvalid_q;

  // Wake queue memory, a circular buffer starting at head_q.
  satq_pkg::q_entry_t qmem [N];
  logic               q_we;
  logic [AW-1:0]      q_waddr;
  satq_pkg::q_entry_t q_wdata;
  logic [AW-1:0]      q_raddr;
  satq_pkg::q_entry_t q_rdata_q;

  logic              in_fire, out_fire, out_last;
  logic [TW:0]       bsum;
  logic [TW-1:0]     base_rd, newb;
  satq_pkg::q_entry_t ent;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign out_last = (ocnt_q == nres_q - CW'(1));
  assign ent      = q_rdata_q;

  // A never-written base time reads as zero.
  assign base_rd = b_rvalid_q ? b_rdata_q : '0;
  assign bsum    = {1'b0, base_rd} + {1'b0, delay_q};
  assign newb    = bsum[TW] ? {TW{1'b1}} : bsum[TW-1:0];

  always_comb begin
    state_d  = state_q;
    id_d     = id_q;
    delay_d  = delay_q;
    now_d    = now_q;
    newb_d   = newb_q;
    pos_d    = pos_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    flags_d  = flags_q;
    bvalid_d = bvalid_q;
    cmp_d    = cmp_q;
    irq_d    = irq_q;
    rkind_d  = rkind_q;
    rid_d    = rid_q;
    nres_d   = nres_q;
    ocnt_d   = ocnt_q;
    wcnt_d   = wcnt_q;
    wbuf_we  = 1'b0;
    b_we     = 1'b0;
    b_addr   = in_id[AW-1:0];
    b_wdata  = in_now;
    q_we     = 1'b0;
    q_waddr  = head_q;
    q_wdata  = '{wake: newb_q, slot: id_q};
    q_raddr  = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          id_d    = in_id;
          delay_d = in_delay;
          now_d   = in_now;
          nres_d  = CW'(1);
          ocnt_d  = '0;
          rid_d   = in_id;
          priority if (in_op == satq_pkg::OP_TICK) begin
            wcnt_d  = '0;
            state_d = S_TICK;
          end else if (in_op == satq_pkg::OP_BAD
                       || {1'b0, in_id} >= (IW+1)'(N)
                       || flags_q[in_id[AW-1:0]]
                       || (in_op == satq_pkg::OP_SLEEP && cnt_q == CW'(N))) begin
            rkind_d = satq_pkg::K_REJECT;
            state_d = S_OUT;
          end else if (in_op == satq_pkg::OP_INIT) begin
            b_we                      = 1'b1;
            bvalid_d[in_id[AW-1:0]]   = 1'b1;
            rkind_d                   = satq_pkg::K_INIT;
            state_d                   = S_OUT;
          end else begin
            state_d = S_SLEEP;
          end
        end
      end
      S_SLEEP: begin
        b_we                  = 1'b1;
        b_addr                = id_q[AW-1:0];
        b_wdata               = newb;
        bvalid_d[id_q[AW-1:0]] = 1'b1;
        newb_d                = newb;
        if (newb <= now_q) begin
          rkind_d = satq_pkg::K_DUE;
          state_d = S_OUT;
        end else begin
          irq_d = 1'b1;
          if (cnt_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            pos_d   = cnt_q;
            q_raddr = satq_pkg::qptr_add(head_q, cnt_q - CW'(1));
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        // Walk from the tail, moving entries with an equal or later time up.
        q_we    = 1'b1;
        q_waddr = satq_pkg::qptr_add(head_q, pos_q);
        if (ent.wake >= newb_q) begin
          q_wdata = ent;
          pos_d   = pos_q - CW'(1);
          if (pos_q == CW'(1)) begin
            state_d = S_INS_HEAD;
          end else begin
            q_raddr = satq_pkg::qptr_add(head_q, pos_q - CW'(2));
          end
        end else begin
          cnt_d                  = cnt_q + CW'(1);
          flags_d[id_q[AW-1:0]]  = 1'b1;
          rkind_d                = satq_pkg::K_QUEUED;
          state_d                = S_OUT;
        end
      end
      S_INS_HEAD: begin
        q_we                   = 1'b1;
        q_waddr                = head_q;
        cnt_d                  = cnt_q + CW'(1);
        flags_d[id_q[AW-1:0]]  = 1'b1;
        cmp_d                  = newb_q;
        rkind_d                = satq_pkg::K_QUEUED;
        state_d                = S_OUT;
      end
      S_TICK: begin
        if (cnt_q != '0 && ent.wake <= now_q) begin
          head_d                  = satq_pkg::qptr_add(head_q, CW'(1));
          cnt_d                   = cnt_q - CW'(1);
          flags_d[ent.slot[AW-1:0]] = 1'b0;
          wbuf_we                 = 1'b1;
          wcnt_d                  = wcnt_q + CW'(1);
          q_raddr                 = satq_pkg::qptr_add(head_q, CW'(1));
        end else begin
          if (cnt_q == '0) begin
            irq_d = 1'b0;
          end else begin
            cmp_d = ent.wake;
          end
          if (wcnt_q == '0) begin
            rkind_d = satq_pkg::K_NONE;
            rid_d   = '0;
          end else begin
            rkind_d = satq_pkg::K_WOKEN;
            nres_d  = wcnt_q;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_fire) begin
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            ocnt_d = ocnt_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      flags_q  <= '0;
      bvalid_q <= '0;
      cmp_q    <= {TW{1'b1}};
      irq_q    <= 1'b0;
      nres_q   <= '0;
      ocnt_q   <= '0;
      wcnt_q   <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      flags_q  <= flags_d;
      bvalid_q <= bvalid_d;
      cmp_q    <= cmp_d;
      irq_q    <= irq_d;
      nres_q   <= nres_d;
      ocnt_q   <= ocnt_d;
      wcnt_q   <= wcnt_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    delay_q <= delay_d;
    now_q   <= now_d;
    newb_q  <= newb_d;
    rkind_q <= rkind_d;
    rid_q   <= rid_d;
    if (wbuf_we) begin
      wbuf_q[wcnt_q[AW-1:0]] <= ent.slot;
    end
  end

  // Base time memory, registered read.
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[b_addr] <= b_wdata;
    end
    b_rdata_q <= bmem[b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_rvalid_q <= 1'b0;
    end else begin
      b_rvalid_q <= bvalid_q[b_addr];
    end
  end

  // Wake queue memory, registered read. During the insert walk reads and writes never
  // hit the same entry in one cycle: the walk writes two places above where it reads.
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= qmem[q_raddr];
  end

  // Output word, straight from registers held during the S_OUT state.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tuser_o  = rkind_q;
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tdata_o  = {3'b000, irq_q, cmp_q,
                            (rkind_q == satq_pkg::K_WOKEN) ? wbuf_q[ocnt_q[AW-1:0]]
                                                           : rid_q};

  // The queue never holds more entries than there are slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N))
    else $error("queue count overflow");

  // Every queued slot has its flag, and only those.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(flags_q) == int'(cnt_q))
    else $error("queued flags disagree with queue count");

  // After the final result the block is ready for the next word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("not ready after final result");

endmodule

>>> tb/sorted_alarm_timer_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_test: self-checking bench for the alarm timer queue.
// Drives init, sleep, tick and illegal operation words and keeps its own copy
// of the base times and the sorted wake queue. Every output word is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_test;

  typedef struct packed {
    logic [1:0]                  op;
    logic [satq_pkg::ID_W-1:0]   id;
    logic [satq_pkg::TIME_W-1:0] delay;
    logic [satq_pkg::TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]                  kind;
    logic [satq_pkg::ID_W-1:0]   slot;
    logic [satq_pkg::TIME_W-1:0] cmp;
    logic                        irq;
    logic                        last;
  } alarm_result_t;

  localparam int WAKE_MAX = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [135:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic [2:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  sorted_alarm_timer_queue i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state of the block.
  logic [satq_pkg::TIME_W-1:0] base_q[satq_pkg::NUM_ALARMS];
  int unsigned                 wake_order[$];
  logic [satq_pkg::NUM_ALARMS-1:0] armed;
  logic [satq_pkg::TIME_W-1:0] cmp_q;
  logic                        irq_q;

  cmd_t          pending_cmds[$];
  alarm_result_t expected_results[$];
  int  errors = 0;
  int  words_out = 0;
  int  wakes_seen = 0;
  bit  calm = 1'b0;   // no idling in the closing part of the run
  bit  hold = 1'b0;   // sender holds back while draining

  // Compute the results one command causes and advance the predicted state.
  task automatic predict_alarm_step(input cmd_t c);
    alarm_result_t r[$];
    logic [satq_pkg::TIME_W-1:0] t;
    int pos;
    int slot;
    if (c.op == satq_pkg::OP_TICK) begin
      while (wake_order.size() > 0 && r.size() < WAKE_MAX &&
             base_q[wake_order[0]] <= c.now) begin
        slot = wake_order.pop_front();
        armed[slot] = 1'b0;
        r.push_back('{satq_pkg::K_WOKEN, satq_pkg::ID_W'(slot), '0, 1'b0, 1'b0});
      end
      if (wake_order.size() == 0) irq_q = 1'b0;
      else cmp_q = base_q[wake_order[0]];
      if (r.size() == 0) r.push_back('{satq_pkg::K_NONE, '0, '0, 1'b0, 1'b0});
    end else if (c.op == satq_pkg::OP_BAD || armed[c.id]) begin
      r.push_back('{satq_pkg::K_REJECT, c.id, '0, 1'b0, 1'b0});
    end else if (c.op == satq_pkg::OP_INIT) begin
      base_q[c.id] = c.now;
      r.push_back('{satq_pkg::K_INIT, c.id, '0, 1'b0, 1'b0});
    end else if (wake_order.size() >= satq_pkg::NUM_ALARMS) begin
      r.push_back('{satq_pkg::K_REJECT, c.id, '0, 1'b0, 1'b0});
    end else begin
      t = base_q[c.id] + c.delay;
      if (t < base_q[c.id]) t = '1;  // saturate on overflow
      base_q[c.id] = t;
      if (t <= c.now) begin
        r.push_back('{satq_pkg::K_DUE, c.id, '0, 1'b0, 1'b0});
      end else begin
        // Insert ahead of entries with an equal wake time.
        pos = 0;
        while (pos < wake_order.size() && base_q[wake_order[pos]] < t) pos++;
        wake_order.insert(pos, c.id);
        armed[c.id] = 1'b1;
        if (pos == 0) cmp_q = t;
        irq_q = 1'b1;
        r.push_back('{satq_pkg::K_QUEUED, c.id, '0, 1'b0, 1'b0});
      end
    end
    foreach (r[k]) begin
      r[k].cmp  = cmp_q;
      r[k].irq  = irq_q;
      r[k].last = (k == r.size() - 1);
      expected_results.push_back(r[k]);
    end
  endtask

  // Driver: one command word per handshake, random idle bursts.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_alarm_step(pending_cmds.pop_front());
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_cmds.size() > 0 && !hold) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= pending_cmds[0].op;
          s_axis_tdata_i  <= {4'b0, pending_cmds[0].now, pending_cmds[0].delay,
                              pending_cmds[0].id};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    alarm_result_t e;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        words_out++;
        if (m_axis_tuser_o == satq_pkg::K_WOKEN) wakes_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word kind=%0d", m_axis_tuser_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (m_axis_tuser_o !== e.kind) begin
            $error("kind: expected %0d got %0d", e.kind, m_axis_tuser_o);
            errors++;
          end
          if (m_axis_tdata_o[3:0] !== e.slot) begin
            $error("woken_id: expected %0d got %0d", e.slot, m_axis_tdata_o[3:0]);
            errors++;
          end
          if (m_axis_tdata_o[67:4] !== e.cmp) begin
            $error("compare_time: expected %h got %h", e.cmp, m_axis_tdata_o[67:4]);
            errors++;
          end
          if (m_axis_tdata_o[68] !== e.irq) begin
            $error("interrupt_on: expected %0d got %0d", e.irq, m_axis_tdata_o[68]);
            errors++;
          end
          if (m_axis_tlast_o !== e.last) begin
            $error("last: expected %0d got %0d", e.last, m_axis_tlast_o);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 5);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic cmd_t mk(input logic [1:0] op, input int id,
                              input logic [63:0] dly, input logic [63:0] now);
    mk = '{op, satq_pkg::ID_W'(id), dly, now};
  endfunction

  // Random wide value with a bias toward small, huge and edge numbers.
  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 4))
      0: rnd64 = {$urandom, $urandom};
      1: rnd64 = 64'($urandom_range(0, 40));
      2: rnd64 = '1 - 64'($urandom_range(0, 3));
      default: rnd64 = 64'($urandom_range(0, 400));
    endcase
  endfunction

  logic [63:0] clock_now;

  initial begin
    foreach (base_q[i]) base_q[i] = '0;
    armed = '0;
    cmp_q = '1;
    irq_q = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edge values, every operation and each corner case.
    pending_cmds.push_back(mk(satq_pkg::OP_TICK, 0, 0, 0));     // nothing due, empty
    pending_cmds.push_back(mk(satq_pkg::OP_BAD, 5, '1, '1));    // unknown operation
    pending_cmds.push_back(mk(satq_pkg::OP_SLEEP, 15, '1, 0));  // sums to all ones
    pending_cmds.push_back(mk(satq_pkg::OP_INIT, 15, 0, 7));    // init of queued slot
    pending_cmds.push_back(mk(satq_pkg::OP_SLEEP, 15, 3, 0));   // sleep of queued slot
    pending_cmds.push_back(mk(satq_pkg::OP_INIT, 0, 0, 100));
    pending_cmds.push_back(mk(satq_pkg::OP_SLEEP, 0, 0, 100));  // already due
    pending_cmds.push_back(mk(satq_pkg::OP_INIT, 1, 0, 10));
    pending_cmds.push_back(mk(satq_pkg::OP_SLEEP, 1, 50, 20));  // wakes at 60
    pending_cmds.push_back(mk(satq_pkg::OP_INIT, 2, 0, 10));
    pending_cmds.push_back(mk(satq_pkg::OP_SLEEP, 2, 50, 20));  // equal time, goes first
    pending_cmds.push_back(mk(satq_pkg::OP_TICK, 0, 0, 59));    // nothing due yet
    pending_cmds.push_back(mk(satq_pkg::OP_TICK, 9, '1, 60));   // wakes two in order
    pending_cmds.push_back(mk(satq_pkg::OP_TICK, 0, 0, '1));    // wakes slot 15
    for (int i = 0; i < 16; i++) pending_cmds.push_back(mk(satq_pkg::OP_INIT, i, 0, 0));
    for (int i = 0; i < 16; i++)
      pending_cmds.push_back(mk(satq_pkg::OP_SLEEP, i, 64'(5 + i % 3), 1));  // fill
    pending_cmds.push_back(mk(satq_pkg::OP_TICK, 0, 0, '1));    // sixteen wakes

    // Random: a mix of init, sleep, tick and illegal words with a slowly advancing time, then a final tick.
    clock_now = 64'd1000;
    for (int n = 0; n < 82; n++) begin
      if (n == 40) begin
        wait (pending_cmds.size() == 0);
        hold = 1'b1;
        wait (!s_axis_tvalid_i && expected_results.size() == 0);
        repeat (25) @(posedge clk_i);
        hold = 1'b0;
      end
      if (n == 65) begin
        wait (pending_cmds.size() == 0);
        calm = 1'b1;
      end
      clock_now = clock_now + 64'($urandom_range(0, 30));
      case ($urandom_range(0, 9))
        0, 1, 2: pending_cmds.push_back(mk(satq_pkg::OP_INIT, $urandom_range(0, 15),
                                           rnd64(),
                                           ($urandom_range(0, 5) == 0) ? rnd64()
                                                                       : clock_now));
        3, 4, 5, 6: pending_cmds.push_back(mk(satq_pkg::OP_SLEEP, $urandom_range(0, 15),
                                              rnd64(), clock_now));
        7, 8: pending_cmds.push_back(mk(satq_pkg::OP_TICK, $urandom_range(0, 15),
                                        rnd64(),
                                        ($urandom_range(0, 6) == 0) ? '1
                                                                     : clock_now));
        default: pending_cmds.push_back(mk(satq_pkg::OP_BAD, $urandom_range(0, 15),
                                           rnd64(), rnd64()));
      endcase
    end
    pending_cmds.push_back(mk(satq_pkg::OP_TICK, 0, 0, '1));

    wait (pending_cmds.size() == 0 && !s_axis_tvalid_i &&
          expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Checked %0d result words, %0d of them wake-ups, over directed corners",
             words_out, wakes_seen);
    $display("and random init, sleep, tick and illegal words with stalls on both sides.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[sorted_alarm_timer_queue] OK");
    end else begin
      $display("[sorted_alarm_timer_queue] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[sorted_alarm_timer_queue] ERROR");
    $finish;
  end

endmodule
